### rtl/sfcs_pkg.sv
// Shared types, codes and helper functions for the SPI flash command sequencer.
package sfcs_pkg;

    localparam int ADDR_BITS  = 24;
    localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;
    localparam int STEP_W     = 3;
    localparam int LEN_W      = 24;
    localparam int GRP_MAX    = 3;
    localparam int GRP_CNT_W  = 2;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // action codes
    localparam logic [1:0] ACT_REQUEST = 2'd0;
    localparam logic [1:0] ACT_DATA    = 2'd1;
    localparam logic [1:0] ACT_RX      = 2'd2;

    // request codes
    localparam logic [2:0] REQ_ID      = 3'd0;
    localparam logic [2:0] REQ_READ    = 3'd1;
    localparam logic [2:0] REQ_STATUS  = 3'd2;
    localparam logic [2:0] REQ_ERASE   = 3'd3;
    localparam logic [2:0] REQ_PROGRAM = 3'd4;

    // result kinds
    localparam logic [2:0] K_SHIFT  = 3'd0;
    localparam logic [2:0] K_CSHIGH = 3'd1;
    localparam logic [2:0] K_DATA   = 3'd2;
    localparam logic [2:0] K_ID     = 3'd3;
    localparam logic [2:0] K_STATUS = 3'd4;
    localparam logic [2:0] K_DONE   = 3'd5;

    // flash opcodes and filler bytes
    localparam logic [7:0] OP_READ_ID = 8'h90;
    localparam logic [7:0] OP_READ    = 8'h03;
    localparam logic [7:0] OP_WREN    = 8'h06;
    localparam logic [7:0] OP_WRDI    = 8'h04;
    localparam logic [7:0] OP_RDSR    = 8'h05;
    localparam logic [7:0] OP_ERASE   = 8'h20;
    localparam logic [7:0] OP_PROGRAM = 8'h02;
    localparam logic [7:0] BYTE_DUMMY = 8'hFF;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] WIP_MASK   = 8'h01;

    localparam logic [STEP_W-1:0] ID_HIGH_STEP = 3'd4;
    localparam logic [STEP_W-1:0] ID_LAST_STEP = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ID,
        PH_ADDR,
        PH_READ,
        PH_STAT_CMD,
        PH_STAT_VAL,
        PH_WREN,
        PH_PWAIT,
        PH_PDATA,
        PH_POLL_CMD,
        PH_POLL_VAL,
        PH_WRDI
    } phase_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  request;
        logic [23:0] address;
        logic [23:0] length;
        logic [7:0]  data_byte;
        logic [7:0]  rx_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic        last;
    } result_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
    } res_t;

    // results caused by one accepted item, res[0] first
    typedef struct packed {
        logic [GRP_CNT_W-1:0] count;
        res_t [GRP_MAX-1:0]   res;
    } group_t;

    typedef struct packed {
        logic   valid;
        group_t grp;
    } grp_push_t;

    // byte sent after the opcode of read ID, by step
    function automatic logic [7:0] id_seq_byte(input logic [STEP_W-1:0] step);
        logic [7:0] b;
        b = (step >= ID_HIGH_STEP) ? BYTE_DUMMY : BYTE_ZERO;
        return b;
    endfunction

    // address byte k (1 = most significant)
    function automatic logic [7:0] addr_byte(input logic [ADDR_BITS-1:0] a,
                                             input logic [STEP_W-1:0] k);
        logic [31:0] wide;
        int          sh;
        wide = 32'(a);
        sh   = 8 * (ADDR_BYTES - int'(k));
        return 8'(wide >> sh);
    endfunction

endpackage

### rtl/spi_flash_command_sequencer_core.sv
// Top level of the SPI flash command sequencer: front end, group queue, back end.
//
//  Channel   Handshake          Payload          Direction
//  -------   ----------------   --------------   ---------
//  cmd       push / full        cmd_item_t       in
//  result    empty / pop        result_item_t    out
//
// A request is taken while full is low; the front end updates the phase and queues
// the one to three results it causes as one group (none: nothing is queued).
// The back end loads a group from the queue into its output register and hands out
// one result per cycle from it while pop is high. full rises only when the four-deep
// group queue is full; a stalled result side holds up requests only then. rst_n
// (asynchronous) clears phase, queue and output.
module spi_flash_command_sequencer_core
    import sfcs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  cmd_item_t    cmd,
    output logic         empty,
    input  logic         pop,
    output result_item_t result
);

    grp_push_t grp_push;
    group_t    head;
    logic      q_empty;
    logic      q_full;
    logic      q_pop;
    logic      accept;

    // a request is taken whenever the queue has room for its group
    assign full   = q_full;
    assign accept = push && !q_full;

    sfcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd      (cmd),
        .grp_push (grp_push)
    );

    sfcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .grp_push (grp_push),
        .pop      (q_pop),
        .head     (head),
        .q_empty  (q_empty),
        .q_full   (q_full)
    );

    sfcs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

### rtl/sfcs_front.sv
// Front end: accepts items, runs the command phase machine, emits result groups.
module sfcs_front
    import sfcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  cmd_item_t cmd,
    output grp_push_t grp_push
);

    phase_t                phase_reg, phase_next;
    logic [2:0]            req_reg, req_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [LEN_W-1:0]      left_reg, left_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [7:0]            idh_reg, idh_next;

    logic [LEN_W-1:0]      left_dec;
    logic                  req_ok;
    logic                  addr_more;

    assign left_dec  = left_reg - LEN_W'(1);
    assign req_ok    = (cmd.request <= REQ_PROGRAM);
    assign addr_more = (step_reg < STEP_W'(ADDR_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            req_reg   <= '0;
            addr_reg  <= '0;
            left_reg  <= '0;
            step_reg  <= '0;
            idh_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            req_reg   <= req_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            step_reg  <= step_next;
            idh_reg   <= idh_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        req_next   = req_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        step_next  = step_reg;
        idh_next   = idh_reg;
        if (accept)
        begin
            unique case (cmd.action)
                ACT_REQUEST:
                begin
                    if (phase_reg == PH_IDLE && req_ok)
                    begin
                        req_next  = cmd.request;
                        addr_next = cmd.address[ADDR_BITS-1:0];
                        left_next = cmd.length;
                        step_next = '0;
                        unique case (cmd.request)
                            REQ_ID:     phase_next = PH_ID;
                            REQ_READ:   phase_next = PH_ADDR;
                            REQ_STATUS: phase_next = PH_STAT_CMD;
                            default:    phase_next = PH_WREN;
                        endcase
                    end
                end
                ACT_DATA:
                begin
                    if (phase_reg == PH_PWAIT)
                        phase_next = PH_PDATA;
                end
                ACT_RX:
                begin
                    unique case (phase_reg)
                        PH_ID:
                        begin
                            if (step_reg == ID_HIGH_STEP)
                                idh_next = cmd.rx_byte;
                            if (step_reg >= ID_LAST_STEP)
                                phase_next = PH_IDLE;
                            else
                                step_next = step_reg + STEP_W'(1);
                        end
                        PH_ADDR:
                        begin
                            if (addr_more)
                                step_next = step_reg + STEP_W'(1);
                            else if (req_reg == REQ_READ)
                                phase_next = (left_reg != '0) ? PH_READ : PH_IDLE;
                            else if (req_reg == REQ_PROGRAM && left_reg != '0)
                                phase_next = PH_PWAIT;
                            else
                                phase_next = PH_POLL_CMD;
                        end
                        PH_READ:
                        begin
                            left_next = left_dec;
                            if (left_dec == '0)
                                phase_next = PH_IDLE;
                        end
                        PH_STAT_CMD: phase_next = PH_STAT_VAL;
                        PH_STAT_VAL: phase_next = PH_IDLE;
                        PH_WREN:
                        begin
                            step_next  = '0;
                            phase_next = PH_ADDR;
                        end
                        PH_PDATA:
                        begin
                            left_next  = left_dec;
                            phase_next = (left_dec != '0) ? PH_PWAIT : PH_POLL_CMD;
                        end
                        PH_POLL_CMD: phase_next = PH_POLL_VAL;
                        PH_POLL_VAL:
                            phase_next = ((cmd.rx_byte & WIP_MASK) != '0) ? PH_POLL_CMD
                                                                          : PH_WRDI;
                        PH_WRDI:     phase_next = PH_IDLE;
                        default:     ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // result group
    always_comb
    begin
        group_t g;
        g = '0;
        if (accept)
        begin
            unique case (cmd.action)
                ACT_REQUEST:
                begin
                    if (phase_reg == PH_IDLE && req_ok)
                    begin
                        g.count = 2'd1;
                        g.res[0].kind = K_SHIFT;
                        unique case (cmd.request)
                            REQ_ID:     g.res[0].value = 16'(OP_READ_ID);
                            REQ_READ:   g.res[0].value = 16'(OP_READ);
                            REQ_STATUS: g.res[0].value = 16'(OP_RDSR);
                            default:    g.res[0].value = 16'(OP_WREN);
                        endcase
                    end
                end
                ACT_DATA:
                begin
                    if (phase_reg == PH_PWAIT)
                    begin
                        g.count  = 2'd1;
                        g.res[0] = '{kind: K_SHIFT, value: 16'(cmd.data_byte)};
                    end
                end
                ACT_RX:
                begin
                    unique case (phase_reg) inside
                        PH_ID:
                        begin
                            if (step_reg >= ID_LAST_STEP)
                            begin
                                g.count  = 2'd3;
                                g.res[0] = '{kind: K_CSHIGH, value: '0};
                                g.res[1] = '{kind: K_ID, value: {idh_reg, cmd.rx_byte}};
                                g.res[2] = '{kind: K_DONE, value: '0};
                            end
                            else
                            begin
                                g.count  = 2'd1;
                                g.res[0] = '{kind: K_SHIFT,
                                    value: 16'(id_seq_byte(step_reg + STEP_W'(1)))};
                            end
                        end
                        PH_ADDR:
                        begin
                            if (addr_more)
                            begin
                                g.count  = 2'd1;
                                g.res[0] = '{kind: K_SHIFT,
                                    value: 16'(addr_byte(addr_reg, step_reg + STEP_W'(1)))};
                            end
                            else if (req_reg == REQ_READ)
                            begin
                                if (left_reg != '0)
                                begin
                                    g.count  = 2'd1;
                                    g.res[0] = '{kind: K_SHIFT, value: 16'(BYTE_DUMMY)};
                                end
                                else
                                begin
                                    g.count  = 2'd2;
                                    g.res[0] = '{kind: K_CSHIGH, value: '0};
                                    g.res[1] = '{kind: K_DONE, value: '0};
                                end
                            end
                            else if (!(req_reg == REQ_PROGRAM && left_reg != '0))
                            begin
                                g.count  = 2'd2;
                                g.res[0] = '{kind: K_CSHIGH, value: '0};
                                g.res[1] = '{kind: K_SHIFT, value: 16'(OP_RDSR)};
                            end
                        end
                        PH_READ:
                        begin
                            g.res[0] = '{kind: K_DATA, value: 16'(cmd.rx_byte)};
                            if (left_dec != '0)
                            begin
                                g.count  = 2'd2;
                                g.res[1] = '{kind: K_SHIFT, value: 16'(BYTE_DUMMY)};
                            end
                            else
                            begin
                                g.count  = 2'd3;
                                g.res[1] = '{kind: K_CSHIGH, value: '0};
                                g.res[2] = '{kind: K_DONE, value: '0};
                            end
                        end
                        PH_STAT_CMD, PH_POLL_CMD:
                        begin
                            g.count  = 2'd1;
                            g.res[0] = '{kind: K_SHIFT, value: 16'(BYTE_DUMMY)};
                        end
                        PH_STAT_VAL:
                        begin
                            g.count  = 2'd3;
                            g.res[0] = '{kind: K_CSHIGH, value: '0};
                            g.res[1] = '{kind: K_STATUS, value: 16'(cmd.rx_byte)};
                            g.res[2] = '{kind: K_DONE, value: '0};
                        end
                        PH_WREN:
                        begin
                            g.count  = 2'd2;
                            g.res[0] = '{kind: K_CSHIGH, value: '0};
                            g.res[1] = '{kind: K_SHIFT,
                                value: 16'((req_reg == REQ_ERASE) ? OP_ERASE : OP_PROGRAM)};
                        end
                        PH_PDATA:
                        begin
                            if (left_dec == '0)
                            begin
                                g.count  = 2'd2;
                                g.res[0] = '{kind: K_CSHIGH, value: '0};
                                g.res[1] = '{kind: K_SHIFT, value: 16'(OP_RDSR)};
                            end
                        end
                        PH_POLL_VAL:
                        begin
                            g.count  = 2'd2;
                            g.res[0] = '{kind: K_CSHIGH, value: '0};
                            g.res[1] = '{kind: K_SHIFT,
                                value: 16'(((cmd.rx_byte & WIP_MASK) != '0) ? OP_RDSR
                                                                             : OP_WRDI)};
                        end
                        PH_WRDI:
                        begin
                            g.count  = 2'd2;
                            g.res[0] = '{kind: K_CSHIGH, value: '0};
                            g.res[1] = '{kind: K_DONE, value: '0};
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        grp_push.grp   = g;
        grp_push.valid = (g.count != '0);
    end

endmodule

### rtl/sfcs_queue.sv
// Small FIFO of result groups between the front and back ends.
module sfcs_queue
    import sfcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  grp_push_t grp_push,
    input  logic      pop,
    output group_t    head,
    output logic      q_empty,
    output logic      q_full
);

    group_t              mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign q_empty = (cnt_reg == '0);
    assign q_full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign do_push = grp_push.valid;
    assign do_pop  = pop && !q_empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= grp_push.grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/sfcs_back.sv
// Back end: unpacks result groups and presents one result per cycle while pop is high.
module sfcs_back
    import sfcs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  group_t       head,
    input  logic         q_empty,
    output logic         q_pop,
    output result_item_t result,
    output logic         empty,
    input  logic         pop
);

    group_t                cur_reg, cur_next;
    logic                  valid_reg, valid_next;
    logic [GRP_CNT_W-1:0]  idx_reg, idx_next;
    logic                  is_last;
    logic                  taken;

    assign is_last = (idx_reg == cur_reg.count - GRP_CNT_W'(1));
    assign taken   = valid_reg && pop;
    assign empty   = !valid_reg;

    assign result.kind  = cur_reg.res[idx_reg].kind;
    assign result.value = cur_reg.res[idx_reg].value;
    assign result.last  = is_last;

    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        if (!valid_reg || (taken && is_last))
        begin
            q_pop      = !q_empty;
            valid_next = !q_empty;
            cur_next   = head;
            idx_next   = '0;
        end
        else if (taken)
        begin
            idx_next = idx_reg + GRP_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
